[hw/rtl/gzp_pkg.sv]
`default_nettype none

package gzp_pkg;

  typedef enum logic [3:0] {
    PH_MAGIC0  = 4'd0,
    PH_MAGIC1  = 4'd1,
    PH_METHOD  = 4'd2,
    PH_FLAGS   = 4'd3,
    PH_XLEN0   = 4'd4,
    PH_XLEN1   = 4'd5,
    PH_NAME    = 4'd6,
    PH_COMMENT = 4'd7,
    PH_PAYLOAD = 4'd8,
    PH_TRAIL0  = 4'd9,
    PH_TRAIL1  = 4'd10,
    PH_TRAIL2  = 4'd11,
    PH_TRAIL3  = 4'd12,
    PH_PASS    = 4'd13,
    PH_FAILED  = 4'd14
  } phase_t;

  typedef enum logic [1:0] {
    CMD_SOURCE  = 2'd0,
    CMD_INFLATE = 2'd1,
    CMD_END     = 2'd2,
    CMD_ERROR   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_FLAGS   = 2'd1,
    ERR_CRC     = 2'd2,
    ERR_INFLATE = 2'd3
  } err_t;

  localparam logic [7:0]  MAGIC0_BYTE   = 8'h1f;
  localparam logic [7:0]  MAGIC1_BYTE   = 8'h8b;
  localparam logic [7:0]  METHOD_BYTE   = 8'h08;
  localparam int          FL_HCRC_BIT   = 1;
  localparam int          FL_EXTRA_BIT  = 2;
  localparam int          FL_NAME_BIT   = 3;
  localparam int          FL_COMMENT_BIT = 4;
  localparam logic [7:0]  FL_RESERVED   = 8'he0;
  localparam logic [31:0] CRC_POLY      = 32'hedb88320;
  localparam int          MAX_RESULTS   = 3;
  localparam int          CNT_W         = $clog2(MAX_RESULTS + 1);

  typedef struct packed {
    phase_t      phase;
    logic [7:0]  flags;
    logic [16:0] skip;
    logic [7:0]  xlen_low;
    logic [31:0] crc;
  } state_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    err_t       code;
  } result_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = ~crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return ~c;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/gzp_step.sv]
`default_nettype none

module gzp_step
  import gzp_pkg::*;
(
  input  state_t                   st,
  input  cmd_t                     cmd,
  input  logic [7:0]               b,
  output state_t                   st_next,
  output logic [CNT_W-1:0]         res_cnt,
  output result_t [MAX_RESULTS-1:0] res
);

  phase_t     ph;
  logic       hcrc_skip;
  logic [1:0] idx;
  logic [7:0] want;

  always_comb begin
    st_next   = st;
    res_cnt   = '0;
    res       = '0;
    ph        = st.phase;
    hcrc_skip = 1'b0;
    idx       = 2'(st.phase - PH_TRAIL0);
    want      = st.crc[{idx, 3'b000} +: 8];

    if (st.phase == PH_FAILED) begin
      // sticky error: nothing moves
    end else if (cmd != CMD_SOURCE) begin
      if (st.phase == PH_PAYLOAD) begin
        case (cmd)
          CMD_INFLATE: begin
            st_next.crc = crc_byte(st.crc, b);
            res[0]      = '{kind: KIND_DATA, data: b, code: ERR_NONE};
            res_cnt     = CNT_W'(1);
          end
          CMD_END: begin
            st_next.phase = PH_TRAIL0;
          end
          CMD_ERROR: begin
            st_next.phase = PH_FAILED;
            res[0]        = '{kind: KIND_ERROR, data: 8'd0, code: ERR_INFLATE};
            res_cnt       = CNT_W'(1);
          end
          default: ;
        endcase
      end
    end else if (st.skip != '0) begin
      st_next.skip = st.skip - 17'd1;
    end else begin
      // step past optional fields that are not flagged
      if (ph == PH_XLEN0 && !st.flags[FL_EXTRA_BIT]) ph = PH_NAME;
      if (ph == PH_NAME && !st.flags[FL_NAME_BIT]) ph = PH_COMMENT;
      if (ph == PH_COMMENT && !st.flags[FL_COMMENT_BIT]) begin
        ph        = PH_PAYLOAD;
        hcrc_skip = st.flags[FL_HCRC_BIT];
      end
      st_next.phase = ph;

      if (hcrc_skip) begin
        // this beat is the first header crc byte
        st_next.skip = 17'd1;
      end else begin
        case (ph)
          PH_MAGIC0: begin
            st_next.crc = '0;
            if (b == MAGIC0_BYTE) begin
              st_next.phase = PH_MAGIC1;
            end else begin
              st_next.phase = PH_PASS;
              res[0]        = '{kind: KIND_DATA, data: b, code: ERR_NONE};
              res_cnt       = CNT_W'(1);
            end
          end
          PH_MAGIC1: begin
            if (b == MAGIC1_BYTE) begin
              st_next.phase = PH_METHOD;
            end else begin
              st_next.phase = PH_PASS;
              res[0]        = '{kind: KIND_DATA, data: MAGIC0_BYTE, code: ERR_NONE};
              res[1]        = '{kind: KIND_DATA, data: b, code: ERR_NONE};
              res_cnt       = CNT_W'(2);
            end
          end
          PH_METHOD: begin
            if (b == METHOD_BYTE) begin
              st_next.phase = PH_FLAGS;
            end else begin
              st_next.phase = PH_PASS;
              res[0]        = '{kind: KIND_DATA, data: MAGIC0_BYTE, code: ERR_NONE};
              res[1]        = '{kind: KIND_DATA, data: MAGIC1_BYTE, code: ERR_NONE};
              res[2]        = '{kind: KIND_DATA, data: b, code: ERR_NONE};
              res_cnt       = CNT_W'(3);
            end
          end
          PH_FLAGS: begin
            st_next.flags = b;
            if ((b & FL_RESERVED) != 8'd0) begin
              st_next.phase = PH_FAILED;
              res[0]        = '{kind: KIND_ERROR, data: 8'd0, code: ERR_FLAGS};
              res_cnt       = CNT_W'(1);
            end else begin
              // mtime, xfl and os
              st_next.phase = PH_XLEN0;
              st_next.skip  = 17'd6;
            end
          end
          PH_XLEN0: begin
            st_next.xlen_low = b;
            st_next.phase    = PH_XLEN1;
          end
          PH_XLEN1: begin
            st_next.skip  = {1'b0, b, st.xlen_low};
            st_next.phase = PH_NAME;
          end
          PH_NAME: begin
            if (b == 8'd0) st_next.phase = PH_COMMENT;
          end
          PH_COMMENT: begin
            if (b == 8'd0) begin
              st_next.phase = PH_PAYLOAD;
              if (st.flags[FL_HCRC_BIT]) st_next.skip = 17'd2;
            end
          end
          PH_PAYLOAD: begin
            res[0]  = '{kind: KIND_PAYLOAD, data: b, code: ERR_NONE};
            res_cnt = CNT_W'(1);
          end
          PH_PASS: begin
            res[0]  = '{kind: KIND_DATA, data: b, code: ERR_NONE};
            res_cnt = CNT_W'(1);
          end
          PH_TRAIL0, PH_TRAIL1, PH_TRAIL2, PH_TRAIL3: begin
            if (b != want) begin
              st_next.phase = PH_FAILED;
              res[0]        = '{kind: KIND_ERROR, data: 8'd0, code: ERR_CRC};
              res_cnt       = CNT_W'(1);
            end else if (ph == PH_TRAIL3) begin
              // isize is dropped, then a new member may start
              st_next.skip  = 17'd4;
              st_next.crc   = '0;
              st_next.phase = PH_MAGIC0;
            end else begin
              st_next.phase = phase_t'(ph + 4'd1);
            end
          end
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/gzip_container_parser_core.sv]
// the first result of a beat is offered in the cycle after the beat is taken
// throughput: one input beat per cycle while each beat gives at most one result and the
// output does not stall; a beat that gives k results (k up to 3) holds off input until
// its last result drains from the three-entry result buffer, one result per cycle unless stalled
// reset: synchronous, clears the parser state to expect the first magic byte,
// zeroes the flags, skip counter and crc, and empties the result buffer
`default_nettype none

module gzip_container_parser_core
  import gzp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] command,
  input  wire logic [7:0] data_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      out_kind,
  output logic [7:0]      out_byte,
  output logic [1:0]      error_code,
  output logic            last
);

  state_t                    st;
  state_t                    st_next;
  logic [CNT_W-1:0]          step_cnt;
  result_t [MAX_RESULTS-1:0] step_res;
  result_t [MAX_RESULTS-1:0] slots;
  logic [CNT_W-1:0]          cnt;
  logic                      push;
  logic                      pop;

  gzp_step u_step (
    .st      (st),
    .cmd     (cmd_t'(command)),
    .b       (data_byte),
    .st_next (st_next),
    .res_cnt (step_cnt),
    .res     (step_res)
  );

  // a new beat may enter once the buffer is empty or drains its last entry now
  assign in_stall = (cnt > CNT_W'(1)) || (cnt == CNT_W'(1) && out_stall);
  assign push     = in_valid && !in_stall;
  assign pop      = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase    <= PH_MAGIC0;
      st.flags    <= '0;
      st.skip     <= '0;
      st.xlen_low <= '0;
      st.crc      <= '0;
      cnt         <= '0;
    end else if (push) begin
      st  <= st_next;
      cnt <= step_cnt;
    end else if (pop) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots <= step_res;
    end else if (pop) begin
      for (int i = 0; i < MAX_RESULTS - 1; i++) begin
        slots[i] <= slots[i+1];
      end
    end
  end

  assign out_valid  = (cnt != '0);
  assign out_kind   = slots[0].kind;
  assign out_byte   = slots[0].data;
  assign error_code = slots[0].code;
  assign last       = (cnt == CNT_W'(1));

endmodule

`default_nettype wire

[hw/rtl/gzp_checker.sv]
`default_nettype none

module gzp_checker
  import gzp_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic [1:0] command,
  input wire logic [7:0] data_byte,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [1:0] out_kind,
  input wire logic [7:0] out_byte,
  input wire logic [1:0] error_code,
  input wire logic       last
);

  logic in_beat;
  assign in_beat = in_valid && !in_stall && (command == CMD_SOURCE || data_byte == data_byte);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_kind) && $stable(out_byte)
      && $stable(error_code) && $stable(last))
    else $error("stalled result changed");

  // an error report is the only result of its beat and carries a code
  a_err_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == KIND_ERROR |-> last && out_byte == 8'd0 && error_code != ERR_NONE)
    else $error("malformed error report");

  a_data_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind != KIND_ERROR |-> error_code == ERR_NONE)
    else $error("data result with error code");

  // errors are sticky: nothing follows a delivered error report
  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && out_kind == KIND_ERROR |=> !out_valid)
    else $error("result after error report");

  // more results of the same beat pending means no new beat may enter
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> in_stall && !in_beat)
    else $error("input taken while results pending");

endmodule

bind gzip_container_parser_core gzp_checker u_gzp_checker (.*);

`default_nettype wire
